// File: hw/rtl/gat_pkg.sv
// Shared types, constants and helpers for the global affine alignment engine.
// Used by every module under hw/rtl; depends on nothing else.
package gat_pkg;

  localparam int REF_MAX   = 1024;
  localparam int ALPHABET  = 32;
  localparam int COL_W     = $clog2(REF_MAX);
  localparam int ROW_W     = 16;
  localparam int SYM_W     = 5;
  localparam int SUB_W     = 8;
  localparam int SCORE_W   = 32;
  localparam int LEN_W     = 17;
  localparam int SYM_CMP_W = 7;
  localparam int SUB_DEPTH = ALPHABET * ALPHABET;
  localparam int SUB_AW    = $clog2(SUB_DEPTH);
  localparam int CFG_AW    = 4;

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t NEG_INF = score_t'(32'hC000_0000);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_CELL  = 2'd2;

  localparam logic [1:0] TR_DIAG = 2'd0;
  localparam logic [1:0] TR_DEL  = 2'd1;
  localparam logic [1:0] TR_INS  = 2'd2;

  localparam logic [1:0] REG_OPEN      = 2'd0;
  localparam logic [1:0] REG_GAP       = 2'd1;
  localparam logic [1:0] REG_REF_LEN   = 2'd2;
  localparam logic [1:0] REG_QUERY_LEN = 2'd3;

  // One cell request as it enters the datapath
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             row0;
    logic             col0;
    logic             rend;
    logic             fin;
    logic             sym_ok;
    score_t           bnd_west;
    score_t           bnd_diag;
    score_t           bnd_nh;
  } cell_req_t;

  typedef struct packed {
    logic             s1_valid;
    logic [COL_W-1:0] s1_col;
    logic             s2_valid;
  } cell_stat_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    score_t           h;
    score_t           f;
  } row_wr_t;

  function automatic logic [SUB_AW-1:0] sub_addr(input logic [SYM_W-1:0] qs,
                                                 input logic [SYM_W-1:0] rs);
    logic [SUB_AW+SYM_W-1:0] a;
    a = (SUB_AW+SYM_W)'(qs) * (SUB_AW+SYM_W)'(ALPHABET) + (SUB_AW+SYM_W)'(rs);
    return a[SUB_AW-1:0];
  endfunction

  function automatic logic sym_ok(input logic [SYM_W-1:0] qs,
                                  input logic [SYM_W-1:0] rs);
    return (SYM_CMP_W'(qs) < SYM_CMP_W'(ALPHABET)) &&
           (SYM_CMP_W'(rs) < SYM_CMP_W'(ALPHABET));
  endfunction

endpackage

// File: hw/rtl/gat_sub_table.sv
// Substitution score memory: one write port, one registered read port.
// Depends on gat_pkg.
module gat_sub_table (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [gat_pkg::SUB_AW-1:0]    rd_addr,
  input  logic                          wr_en,
  input  logic [gat_pkg::SUB_AW-1:0]    wr_addr,
  input  logic signed [gat_pkg::SUB_W-1:0] wr_data,
  output logic signed [gat_pkg::SUB_W-1:0] rd_data
);

  logic signed [gat_pkg::SUB_W-1:0] mem [gat_pkg::SUB_DEPTH];
  logic signed [gat_pkg::SUB_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/gat_row_store.sv
// Previous-row H and F store with write-back forwarding for a read that
// coincides with a write. Depends on gat_pkg.
module gat_row_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [gat_pkg::COL_W-1:0]  rd_addr,
  input  gat_pkg::row_wr_t           wr,
  output gat_pkg::score_t            rd_h,
  output gat_pkg::score_t            rd_f
);

  logic [2*gat_pkg::SCORE_W-1:0] mem [gat_pkg::REF_MAX];
  logic [2*gat_pkg::SCORE_W-1:0] rd_q_r;
  logic [gat_pkg::COL_W-1:0]     rd_addr_r;
  logic                          wb_valid_r;
  logic [gat_pkg::COL_W-1:0]     wb_addr_r;
  gat_pkg::score_t               wb_h_r;
  gat_pkg::score_t               wb_f_r;
  logic                          fwd;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.h, wr.f};
    end
  end

  // Capture the write that lands on the same edge as the read; memory
  // returns the old word for it.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
      wb_addr_r <= wr.addr;
      wb_h_r    <= wr.h;
      wb_f_r    <= wr.f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (rd_en) begin
      wb_valid_r <= wr.en;
    end
  end

  assign fwd  = wb_valid_r && (wb_addr_r == rd_addr_r);
  assign rd_h = fwd ? wb_h_r : gat_pkg::score_t'(rd_q_r[2*gat_pkg::SCORE_W-1:gat_pkg::SCORE_W]);
  assign rd_f = fwd ? wb_f_r : gat_pkg::score_t'(rd_q_r[gat_pkg::SCORE_W-1:0]);

endmodule

// File: hw/rtl/gat_cell.sv
// Two-stage cell datapath: vertical gap and diagonal in the first stage,
// horizontal gap, best score and trace in the second, then the result register.
// Depends on gat_pkg.
module gat_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             go,
  input  gat_pkg::cell_req_t               req,
  input  logic [7:0]                       open_pen,
  input  logic [7:0]                       gap_pen,
  input  gat_pkg::score_t                  rd_h,
  input  gat_pkg::score_t                  rd_f,
  input  logic signed [gat_pkg::SUB_W-1:0] sub_q,
  input  logic                             out_ready,
  output gat_pkg::cell_stat_t              stat,
  output gat_pkg::row_wr_t                 row_wr,
  output logic                             out_valid,
  output logic [1:0]                       out_trace_main,
  output logic                             out_del_opened,
  output logic                             out_ins_opened,
  output gat_pkg::score_t                  out_cell_score,
  output logic                             out_row_end,
  output logic                             out_last
);

  typedef struct packed {
    logic [gat_pkg::COL_W-1:0] col;
    logic                      col0;
    logic                      rend;
    logic                      fin;
    logic                      del_open;
    gat_pkg::score_t           bnd_west;
    gat_pkg::score_t           f_new;
    gat_pkg::score_t           h_dag;
  } s2_t;

  logic               s1_valid_r;
  gat_pkg::cell_req_t s1_r;
  logic               s2_valid_r;
  s2_t                s2_r;
  s2_t                s2_nxt;
  gat_pkg::score_t    diag_r;
  gat_pkg::score_t    west_r;
  gat_pkg::score_t    e_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [1:0]         trace_r;
  logic               del_r;
  logic               ins_r;
  gat_pkg::score_t    score_r;
  logic               rend_r;
  logic               last_r;

  gat_pkg::score_t open_s, gap_s;
  gat_pkg::score_t nh, nf, sub, f_opn, f_ext, diag;
  gat_pkg::score_t west, e_in, e_opn, e_ext, e_new, h_mid, h_new;
  logic            ins_open;
  logic [1:0]      tmain;

  assign open_s = gat_pkg::score_t'(open_pen);
  assign gap_s  = gat_pkg::score_t'(gap_pen);

  // Stage one: north cell, vertical gap, diagonal move
  always_comb begin
    nh    = s1_r.row0 ? s1_r.bnd_nh : rd_h;
    nf    = s1_r.row0 ? gat_pkg::NEG_INF : rd_f;
    sub   = s1_r.sym_ok ? gat_pkg::score_t'(sub_q) : '0;
    f_opn = nh - open_s;
    f_ext = nf - gap_s;
    diag  = s1_r.col0 ? s1_r.bnd_diag : diag_r;
    s2_nxt.col      = s1_r.col;
    s2_nxt.col0     = s1_r.col0;
    s2_nxt.rend     = s1_r.rend;
    s2_nxt.fin      = s1_r.fin;
    s2_nxt.del_open = f_opn > f_ext;
    s2_nxt.bnd_west = s1_r.bnd_west;
    s2_nxt.f_new    = (f_opn > f_ext) ? f_opn : f_ext;
    s2_nxt.h_dag    = diag + sub;
  end

  // Stage two: horizontal gap through the west loop, best score
  always_comb begin
    west     = s2_r.col0 ? s2_r.bnd_west : west_r;
    e_in     = s2_r.col0 ? gat_pkg::NEG_INF : e_r;
    e_opn    = west - open_s;
    e_ext    = e_in - gap_s;
    ins_open = e_opn > e_ext;
    e_new    = ins_open ? e_opn : e_ext;
    h_mid    = (s2_r.h_dag > e_new) ? s2_r.h_dag : e_new;
    h_new    = (h_mid > s2_r.f_new) ? h_mid : s2_r.f_new;
    if (h_new == s2_r.h_dag) begin
      tmain = gat_pkg::TR_DIAG;
    end else if (h_new == s2_r.f_new) begin
      tmain = gat_pkg::TR_DEL;
    end else begin
      tmain = gat_pkg::TR_INS;
    end
  end

  always_comb begin
    if (s2_valid_r && adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      diag_r      <= '0;
      west_r      <= '0;
      e_r         <= gat_pkg::NEG_INF;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        s1_valid_r <= go;
        s2_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          diag_r <= nh;
        end
        if (s2_valid_r) begin
          west_r <= h_new;
          e_r    <= e_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (go) begin
        s1_r <= req;
      end
      s2_r <= s2_nxt;
      if (s2_valid_r) begin
        trace_r <= tmain;
        del_r   <= s2_r.del_open;
        ins_r   <= ins_open;
        score_r <= h_new;
        rend_r  <= s2_r.rend;
        last_r  <= s2_r.fin;
      end
    end
  end

  assign row_wr.en   = adv && s2_valid_r;
  assign row_wr.addr = s2_r.col;
  assign row_wr.h    = h_new;
  assign row_wr.f    = s2_r.f_new;

  assign stat.s1_valid = s1_valid_r;
  assign stat.s1_col   = s1_r.col;
  assign stat.s2_valid = s2_valid_r;

  assign out_valid      = out_valid_r;
  assign out_trace_main = trace_r;
  assign out_del_opened = del_r;
  assign out_ins_opened = ins_r;
  assign out_cell_score = score_r;
  assign out_row_end    = rend_r;
  assign out_last       = last_r;

endmodule

// File: hw/rtl/global_affine_alignment_trace.sv
// Global affine-gap alignment engine with traceback decisions. Load the
// substitution table with mode-0 requests, send a start request, then one
// cell request per query/reference pair in row-major order; each cell gives
// one result via the first-stage, second-stage and result registers; the
// last cell's score is the alignment score. Unless the output stalls, the
// rate is one request per cycle, set by the horizontal-gap loop through the
// west score in stage two. With ref_length of one, each cell waits for the
// previous cell's row-store write-back. The row store is never cleared: the
// first row is generated internally, so no fill time is needed.
// Depends on gat_pkg, gat_sub_table, gat_row_store and gat_cell.
module global_affine_alignment_trace (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic [gat_pkg::SYM_W-1:0]           in_query_symbol,
  input  logic [gat_pkg::SYM_W-1:0]           in_ref_symbol,
  input  logic signed [gat_pkg::SUB_W-1:0]    in_sub_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_trace_main,
  output logic                                out_del_opened,
  output logic                                out_ins_opened,
  output logic signed [gat_pkg::SCORE_W-1:0]  out_cell_score,
  output logic                                out_row_end,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gat_pkg::CFG_AW-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [7:0]                 open_r;
  logic [7:0]                 gap_r;
  logic [10:0]                ref_len_r;
  logic [gat_pkg::ROW_W-1:0]  query_len_r;
  logic [gat_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [gat_pkg::ROW_W-1:0]  row_r, row_nxt;

  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;
  logic                       adv;
  logic                       hazard;
  logic                       accept;
  logic                       cell_go;
  logic                       start_go;
  logic                       load_go;
  logic [gat_pkg::LEN_W-1:0]  len_eff;
  logic [gat_pkg::LEN_W-1:0]  qlen_eff;
  logic                       cur_rend;
  logic                       cur_fin;
  logic [23:0]                prod_row;
  logic [gat_pkg::COL_W+7:0]  prod_col;
  gat_pkg::score_t            open_s;
  gat_pkg::score_t            bnd_west;
  gat_pkg::cell_req_t         req;
  gat_pkg::cell_stat_t        stat;
  gat_pkg::row_wr_t           row_wr;
  gat_pkg::score_t            rd_h, rd_f;
  logic signed [gat_pkg::SUB_W-1:0] sub_q;
  gat_pkg::score_t            cell_score;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      gat_pkg::REG_OPEN:      prdata = 32'(open_r);
      gat_pkg::REG_GAP:       prdata = 32'(gap_r);
      gat_pkg::REG_REF_LEN:   prdata = 32'(ref_len_r);
      gat_pkg::REG_QUERY_LEN: prdata = 32'(query_len_r);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 8'd10;
      gap_r       <= 8'd1;
      ref_len_r   <= 11'd1024;
      query_len_r <= 16'd1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gat_pkg::REG_OPEN:      open_r      <= pwdata[7:0];
        gat_pkg::REG_GAP:       gap_r       <= pwdata[7:0];
        gat_pkg::REG_REF_LEN:   ref_len_r   <= pwdata[10:0];
        gat_pkg::REG_QUERY_LEN: query_len_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: the pipeline moves unless a finished result is stuck in
  // the result register with another one behind it.
  assign adv      = out_ready || !out_valid || !stat.s2_valid;
  assign hazard   = stat.s1_valid && (stat.s1_col == col_r);
  assign in_ready = adv && !hazard;
  assign accept   = in_valid && in_ready;
  assign cell_go  = accept && (in_mode == gat_pkg::MODE_CELL);
  assign start_go = accept && (in_mode == gat_pkg::MODE_START);
  assign load_go  = accept && (in_mode == gat_pkg::MODE_LOAD) &&
                    gat_pkg::sym_ok(in_query_symbol, in_ref_symbol);

  // Row and column tracking
  always_comb begin
    if (ref_len_r == '0) begin
      len_eff = gat_pkg::LEN_W'(1);
    end else if (gat_pkg::LEN_W'(ref_len_r) > gat_pkg::LEN_W'(gat_pkg::REF_MAX)) begin
      len_eff = gat_pkg::LEN_W'(gat_pkg::REF_MAX);
    end else begin
      len_eff = gat_pkg::LEN_W'(ref_len_r);
    end
    qlen_eff = (query_len_r == '0) ? gat_pkg::LEN_W'(1) : gat_pkg::LEN_W'(query_len_r);
    cur_rend = (gat_pkg::LEN_W'(col_r) + gat_pkg::LEN_W'(1)) >= len_eff;
    cur_fin  = cur_rend &&
               ((gat_pkg::LEN_W'(row_r) + gat_pkg::LEN_W'(1)) >= qlen_eff);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (start_go) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cell_go) begin
      if (cur_fin) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (cur_rend) begin
        col_nxt = '0;
        row_nxt = row_r + gat_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + gat_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Boundary scores for the first row and the first column
  assign prod_row = 24'(row_r) * 24'(gap_r);
  assign prod_col = (gat_pkg::COL_W+8)'(col_r) * (gat_pkg::COL_W+8)'(gap_r);
  assign open_s   = gat_pkg::score_t'(open_r);
  assign bnd_west = '0 - open_s - gat_pkg::score_t'(prod_row);

  always_comb begin
    req.col      = col_r;
    req.row0     = (row_r == '0);
    req.col0     = (col_r == '0);
    req.rend     = cur_rend;
    req.fin      = cur_fin;
    req.sym_ok   = gat_pkg::sym_ok(in_query_symbol, in_ref_symbol);
    req.bnd_west = bnd_west;
    req.bnd_diag = (row_r == '0) ? '0 : bnd_west + gat_pkg::score_t'(gap_r);
    req.bnd_nh   = '0 - open_s - gat_pkg::score_t'(prod_col);
  end

  gat_sub_table u_sub (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (gat_pkg::sub_addr(in_query_symbol, in_ref_symbol)),
    .wr_en   (load_go),
    .wr_addr (gat_pkg::sub_addr(in_query_symbol, in_ref_symbol)),
    .wr_data (in_sub_value),
    .rd_data (sub_q)
  );

  gat_row_store u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (adv),
    .rd_addr (col_r),
    .wr      (row_wr),
    .rd_h    (rd_h),
    .rd_f    (rd_f)
  );

  gat_cell u_cell (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .go             (cell_go),
    .req            (req),
    .open_pen       (open_r),
    .gap_pen        (gap_r),
    .rd_h           (rd_h),
    .rd_f           (rd_f),
    .sub_q          (sub_q),
    .out_ready      (out_ready),
    .stat           (stat),
    .row_wr         (row_wr),
    .out_valid      (out_valid),
    .out_trace_main (out_trace_main),
    .out_del_opened (out_del_opened),
    .out_ins_opened (out_ins_opened),
    .out_cell_score (cell_score),
    .out_row_end    (out_row_end),
    .out_last       (out_last)
  );

  assign out_cell_score = cell_score;

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cell_go && cur_fin |=> (col_r == '0) && (row_r == '0))
    else $error("counters not cleared after final cell");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cell_go && cur_rend && !cur_fin |=>
      (col_r == '0) && (row_r == gat_pkg::ROW_W'($past(row_r) + gat_pkg::ROW_W'(1))))
    else $error("row did not advance at row end");

  a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row_end)
    else $error("final cell without row end");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && stat.s2_valid |-> !in_ready)
    else $error("request taken while pipeline is frozen");

  a_no_col_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    cell_go && !req.rend |=> !(stat.s1_valid && (stat.s1_col == col_r)))
    else $error("next column collides with cell in first stage");

endmodule
